[hw/rtl/mdu_pkg.sv]
package mdu_pkg;

  localparam int Xlen = 64;
  localparam int OpW = 3;

  typedef enum logic [OpW-1:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } op_t;

  // Pipeline row: one cell per quotient bit, each retiring one restoring step.
  localparam int NumCells = Xlen;

  // Everything a cell hands to its right neighbor.
  typedef struct packed {
    logic             vld;
    logic             is_div;
    logic             want_rem;
    logic             neg_q;
    logic             neg_r;
    logic             special;
    logic [Xlen-1:0]  special_val;
    logic [Xlen-1:0]  rem;
    logic [Xlen-1:0]  quo;
    logic [Xlen-1:0]  divisor;
    logic [Xlen-1:0]  mul_res;
  } cell_t;

endpackage

[hw/rtl/mdu_if.sv]
interface mdu_in_if;
  import mdu_pkg::*;
  logic            valid;
  logic            ready;
  logic [2:0]      operation;
  logic [63:0]     operand_a;
  logic [63:0]     operand_b;
  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input operation, input operand_a, input operand_b,
                output ready);
endinterface

interface mdu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  modport source (output valid, output result_value, input ready);
  modport sink (input valid, input result_value, output ready);
endinterface

[hw/rtl/mdu_cell.sv]
module mdu_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  mdu_pkg::cell_t  cin,
  output mdu_pkg::cell_t  cout
);
  import mdu_pkg::*;

  cell_t              c_r, c_nxt;
  logic [Xlen:0]      part;
  logic [Xlen:0]      diff;

  // One restoring division step: shift in the next dividend bit and try a subtract.
  always_comb begin
    c_nxt = cin;
    part  = {cin.rem, cin.quo[Xlen-1]};
    diff  = part - {1'b0, cin.divisor};
    if (cin.is_div) begin
      c_nxt.quo = {cin.quo[Xlen-2:0], ~diff[Xlen]};
      c_nxt.rem = diff[Xlen] ? part[Xlen-1:0] : diff[Xlen-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r.vld <= c_nxt.vld;
    end
    if (en) begin
      c_r.is_div      <= c_nxt.is_div;
      c_r.want_rem    <= c_nxt.want_rem;
      c_r.neg_q       <= c_nxt.neg_q;
      c_r.neg_r       <= c_nxt.neg_r;
      c_r.special     <= c_nxt.special;
      c_r.special_val <= c_nxt.special_val;
      c_r.rem         <= c_nxt.rem;
      c_r.quo         <= c_nxt.quo;
      c_r.divisor     <= c_nxt.divisor;
      c_r.mul_res     <= c_nxt.mul_res;
    end
  end

  assign cout = c_r;
endmodule

[hw/rtl/mdu_front.sv]
module mdu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld,
  input  logic [2:0]      operation,
  input  logic [63:0]     operand_a,
  input  logic [63:0]     operand_b,
  output mdu_pkg::cell_t  cout
);
  import mdu_pkg::*;

  localparam int Hw = Xlen / 2;

  // Stage 1 registers: operation decode and four 32x32 partial products.
  cell_t               s1_r;
  logic [Xlen-1:0]     a_r, b_r;
  logic                sa_r, sb_r;
  logic [2*Hw-1:0]     pll_r, plh_r, phl_r, phh_r;
  logic                mhigh_r;

  op_t                 op;
  logic [Xlen-1:0]     a, b, ma, mb;
  logic                na, nb, sa, sb, sgn, dz, ovf;
  cell_t               c_nxt;

  always_comb begin
    op  = op_t'(operation);
    a   = operand_a[Xlen-1:0];
    b   = operand_b[Xlen-1:0];
    sgn = (op == OP_DIV) || (op == OP_REM);
    na  = sgn && a[Xlen-1];
    nb  = sgn && b[Xlen-1];
    ma  = na ? (~a + 1'b1) : a;
    mb  = nb ? (~b + 1'b1) : b;
    dz  = (b == '0);
    ovf = sgn && (a == {1'b1, {(Xlen-1){1'b0}}}) && (b == '1);
    sa  = (op == OP_MULH) || (op == OP_MULHSU);
    sb  = (op == OP_MULH);
    c_nxt             = '0;
    c_nxt.vld         = vld;
    c_nxt.is_div      = operation[2];
    c_nxt.want_rem    = operation[1];
    c_nxt.neg_q       = na ^ nb;
    c_nxt.neg_r       = na;
    c_nxt.special     = operation[2] && (dz || ovf);
    if (dz) begin
      c_nxt.special_val = operation[1] ? a : '1;
    end else begin
      c_nxt.special_val = operation[1] ? '0 : a;
    end
    c_nxt.quo         = ma;
    c_nxt.divisor     = mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (en) begin
      s1_r.vld <= c_nxt.vld;
    end
    if (en) begin
      s1_r.is_div      <= c_nxt.is_div;
      s1_r.want_rem    <= c_nxt.want_rem;
      s1_r.neg_q       <= c_nxt.neg_q;
      s1_r.neg_r       <= c_nxt.neg_r;
      s1_r.special     <= c_nxt.special;
      s1_r.special_val <= c_nxt.special_val;
      s1_r.rem         <= '0;
      s1_r.quo         <= c_nxt.quo;
      s1_r.divisor     <= c_nxt.divisor;
      s1_r.mul_res     <= '0;
      a_r     <= a;
      b_r     <= b;
      sa_r    <= sa && a[Xlen-1];
      sb_r    <= sb && b[Xlen-1];
      mhigh_r <= (op != OP_MUL);
      pll_r   <= a[Hw-1:0] * b[Hw-1:0];
      plh_r   <= a[Hw-1:0] * b[Xlen-1:Hw];
      phl_r   <= a[Xlen-1:Hw] * b[Hw-1:0];
      phh_r   <= a[Xlen-1:Hw] * b[Xlen-1:Hw];
    end
  end

  // Stage 2: sum the partial products, then the signed corrections on the high half.
  logic [2*Xlen-1:0] prod;
  logic [Xlen-1:0]   hi;
  always_comb begin
    prod = {{Xlen{1'b0}}, pll_r} + ({{Hw{1'b0}}, plh_r, {Hw{1'b0}}})
         + ({{Hw{1'b0}}, phl_r, {Hw{1'b0}}}) + {phh_r, {Xlen{1'b0}}};
    hi = prod[2*Xlen-1:Xlen] - (sa_r ? b_r : '0) - (sb_r ? a_r : '0);
  end

  cell_t s2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else if (en) begin
      s2_r.vld <= s1_r.vld;
    end
    if (en) begin
      s2_r.is_div      <= s1_r.is_div;
      s2_r.want_rem    <= s1_r.want_rem;
      s2_r.neg_q       <= s1_r.neg_q;
      s2_r.neg_r       <= s1_r.neg_r;
      s2_r.special     <= s1_r.special;
      s2_r.special_val <= s1_r.special_val;
      s2_r.rem         <= s1_r.rem;
      s2_r.quo         <= s1_r.quo;
      s2_r.divisor     <= s1_r.divisor;
      s2_r.mul_res     <= mhigh_r ? hi : prod[Xlen-1:0];
    end
  end

  assign cout = s2_r;
endmodule

[hw/rtl/multiply_divide_unit.sv]
// From request to result, a request passes through two front
// stages, the XLEN divider cells and the output register.
// Throughput: one request per cycle; every stage is a register in one pipeline
// that advances whenever the output register is empty or being taken.
// The divider is a row of XLEN identical cells, one quotient bit each.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
module multiply_divide_unit (
  input logic     clk,
  input logic     rst_n,
  mdu_in_if.sink  in_ch,
  mdu_out_if.source out_ch
);
  import mdu_pkg::*;

  logic               en;
  cell_t              row [NumCells+1];
  logic               out_vld_r;
  logic [63:0]        out_val_r;
  logic [Xlen-1:0]    q, r, v;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  mdu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld       (in_ch.valid),
    .operation (in_ch.operation),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .cout      (row[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    mdu_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .cin  (row[i]),
      .cout (row[i+1])
    );
  end

  always_comb begin
    q = row[NumCells].neg_q ? (~row[NumCells].quo + 1'b1) : row[NumCells].quo;
    r = row[NumCells].neg_r ? (~row[NumCells].rem + 1'b1) : row[NumCells].rem;
    if (!row[NumCells].is_div) begin
      v = row[NumCells].mul_res;
    end else if (row[NumCells].special) begin
      v = row[NumCells].special_val;
    end else begin
      v = row[NumCells].want_rem ? r : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= row[NumCells].vld;
    end
    if (en) begin
      out_val_r <= 64'(v);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = out_val_r;
endmodule

[hw/rtl/mdu_checker.sv]
module mdu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result_value
);
  import mdu_pkg::*;

  // A stalled output must not lose or change its request.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("output changed while stalled");

  // The input side is ready exactly when the output register can move.
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output state");

  // Nothing comes out right after reset, long before any request could finish.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind multiply_divide_unit mdu_checker u_mdu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.result_value)
);
